// ===== design/bdlp_pkg.sv =====
// Shared types and constants for the button debounce and long-press qualifier.
package bdlp_pkg;

  // Buttons handled, bit order in the level and event vectors
  localparam int unsigned NUM_BTN     = 3;
  localparam int unsigned BTN_INSPECT = 0;
  localparam int unsigned BTN_MODE    = 1;
  localparam int unsigned BTN_POWER   = 2;

  // Field widths
  localparam int unsigned TIME_W = 32;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned EVT_W  = 2;

  // Stream data widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 8;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_MS = 1'b1;

  // Register reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_MS_RST   = 16'd30;
  localparam logic [CFG_W-1:0] LONG_PRESS_MS_RST = 16'd2000;

  // Event code reported per button
  typedef enum logic [EVT_W-1:0] {
    EVT_NONE  = 2'd0,
    EVT_SHORT = 2'd1,
    EVT_LONG  = 2'd2
  } evt_t;

endpackage

// ===== design/button_debounce_long_press.sv =====
// Top level: three-button debounce with short and long press events.
// Each item is one poll (timestamp and three raw active-low levels) and gives
// exactly one result item with an event code per button. One item is taken
// every clock cycle while the output is not stalled; an item passes an input
// register and then the result register, which holds its result for the output.
// All per-button work (one 32-bit subtract and compare for the debounce time,
// one for the hold time) sits between those two registers, and the button
// state is updated as the item moves into the result register. in_tready stays
// high while the input register is empty or moving on, so a finished result
// may wait in the output register while the next item is taken. Configuration
// writes take effect on the next cycle.
module button_debounce_long_press
  import bdlp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // poll items
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // now_ms[31:0], inspect_level, mode_level,
                                            // power_level, zero pad
  // event items
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // inspect_event[1:0], mode_event,
                                            // power_event, zero pad
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  // Configuration registers
  logic [CFG_W-1:0] debounce_r;
  logic [CFG_W-1:0] long_press_r;

  // Input stage
  logic               s1_valid_r;
  logic [TIME_W-1:0]  s1_now_r;
  logic [NUM_BTN-1:0] s1_lvl_r;

  // Result stage
  logic                     out_valid_r;
  logic [NUM_BTN*EVT_W-1:0] out_evt_r;

  // Per-button state
  logic [NUM_BTN-1:0] prev_r;
  logic [NUM_BTN-1:0] stable_r;
  logic [NUM_BTN-1:0] lr_r;
  logic [TIME_W-1:0]  chg_r   [NUM_BTN];
  logic [TIME_W-1:0]  press_r [NUM_BTN];

  // Next-state values
  logic [NUM_BTN-1:0] stable_nxt;
  logic [NUM_BTN-1:0] lr_nxt;
  logic [NUM_BTN-1:0] accept_lvl;
  logic [TIME_W-1:0]  chg_nxt     [NUM_BTN];
  logic [TIME_W-1:0]  press_nxt   [NUM_BTN];
  logic [TIME_W-1:0]  since_chg   [NUM_BTN];
  logic [TIME_W-1:0]  since_press [NUM_BTN];
  evt_t               evt_nxt     [NUM_BTN];
  logic [NUM_BTN*EVT_W-1:0] evt_vec;

  logic advance;
  logic fire;

  // Handshake
  assign advance    = !out_valid_r || out_tready;
  assign fire       = s1_valid_r && advance;
  assign in_tready  = !s1_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - NUM_BTN*EVT_W){1'b0}}, out_evt_r};

  // Configuration write decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_MS_RST;
      long_press_r <= LONG_PRESS_MS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE_MS:   debounce_r   <= cfg_wdata;
        REG_LONG_PRESS_MS: long_press_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_now_r <= in_tdata[TIME_W-1:0];
      s1_lvl_r <= in_tdata[TIME_W +: NUM_BTN];
    end
  end

  // Per-button qualification of the registered poll
  always_comb begin
    for (int b = 0; b < NUM_BTN; b++) begin
      // a level change restarts the debounce time
      chg_nxt[b]    = (s1_lvl_r[b] != prev_r[b]) ? s1_now_r : chg_r[b];
      since_chg[b]  = s1_now_r - chg_nxt[b];
      accept_lvl[b] = since_chg[b] > {{(TIME_W - CFG_W){1'b0}}, debounce_r};

      stable_nxt[b] = stable_r[b];
      press_nxt[b]  = press_r[b];
      lr_nxt[b]     = lr_r[b];
      evt_nxt[b]    = EVT_NONE;

      // stable edge: press records time, release may give a short event
      if (accept_lvl[b] && (s1_lvl_r[b] != stable_r[b])) begin
        stable_nxt[b] = s1_lvl_r[b];
        if (!s1_lvl_r[b]) begin
          press_nxt[b] = s1_now_r;
          lr_nxt[b]    = 1'b0;
        end else if (!lr_r[b]) begin
          evt_nxt[b] = EVT_SHORT;
        end
      end

      // one long event per hold
      since_press[b] = s1_now_r - press_nxt[b];
      if (accept_lvl[b] && !stable_nxt[b] && !lr_nxt[b] &&
          (since_press[b] >= {{(TIME_W - CFG_W){1'b0}}, long_press_r})) begin
        lr_nxt[b]  = 1'b1;
        evt_nxt[b] = EVT_LONG;
      end

      evt_vec[b*EVT_W +: EVT_W] = evt_nxt[b];
    end
  end

  // Button state, updated as the item moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= '1;
      stable_r <= '1;
      lr_r     <= '0;
      for (int b = 0; b < NUM_BTN; b++) begin
        chg_r[b]   <= '0;
        press_r[b] <= '0;
      end
    end else if (fire) begin
      prev_r   <= s1_lvl_r;
      stable_r <= stable_nxt;
      lr_r     <= lr_nxt;
      for (int b = 0; b < NUM_BTN; b++) begin
        chg_r[b]   <= chg_nxt[b];
        press_r[b] <= press_nxt[b];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_evt_r <= evt_vec;
    end
  end

  // Checks
  a_long_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && evt_nxt[BTN_INSPECT] == EVT_LONG) |=> lr_r[BTN_INSPECT])
    else $error("long event without long flag set");

  a_short_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && evt_nxt[BTN_POWER] == EVT_SHORT) |=> stable_r[BTN_POWER])
    else $error("short event while button still held");

  a_no_bad_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_evt_r[1:0] != 2'b11 && out_evt_r[3:2] != 2'b11 &&
                     out_evt_r[5:4] != 2'b11))
    else $error("undefined event code in result");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(fire) |-> ($stable(stable_r) && $stable(lr_r) && $stable(prev_r)))
    else $error("button state changed without an item");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("empty input stage not ready");

endmodule
